[sv/pwmps_pkg.sv]
// Shared types, widths and constants of the PWM period, prescaler and duty set-up block.
package pwmps_pkg;

  localparam int unsigned ClkHzW   = 27;
  localparam int unsigned FreqW    = 32;
  localparam int unsigned DutyW    = 16;
  localparam int unsigned PctW     = 8;
  localparam int unsigned ChanW    = 3;
  localparam int unsigned PeriodW  = 9;
  localparam int unsigned Duty10W  = 10;
  localparam int unsigned ByteW    = 8;

  // Serial divider: the dividend is as wide as the clock register.
  localparam int unsigned DivNumW  = ClkHzW;
  localparam int unsigned DivDenW  = FreqW;
  localparam int unsigned DivCntW  = $clog2(DivNumW);

  localparam int unsigned RatioMax       = 4096;
  localparam int unsigned RatioPrescale1 = 256;
  localparam int unsigned RatioPrescale4 = 1024;
  localparam int unsigned DutyMax        = 1023;
  localparam int unsigned PctFull        = 100;
  localparam int unsigned PctDivisor     = 25;
  localparam int unsigned ClkHzReset     = 12000000;
  localparam int unsigned PeriodReset    = 256;

  localparam logic [ByteW-1:0] TconPrescale1  = 8'b0000_0100;
  localparam logic [ByteW-1:0] TconPrescale4  = 8'b0000_0101;
  localparam logic [ByteW-1:0] TconPrescale16 = 8'b0000_0110;
  localparam logic [ByteW-1:0] PwmMode        = 8'b0000_1100;

  typedef enum logic [1:0] {
    KIND_FREQ    = 2'd0,
    KIND_DUTY    = 2'd1,
    KIND_PERCENT = 2'd2,
    KIND_NONE    = 2'd3
  } kind_e;

  typedef struct packed {
    logic             status;
    logic [ByteW-1:0] period_register;
    logic [ByteW-1:0] timer_control;
    logic [ChanW-1:0] channel_written;
    logic [ByteW-1:0] duty_high;
    logic [ByteW-1:0] channel_control;
    logic             duty_applied;
  } result_t;

  // Handshake between the sequencer and the serial divider.
  typedef struct packed {
    logic busy;
    logic last;
  } div_stat_t;

endpackage

[sv/pwmps_in_if.sv]
// Command channel interface of the PWM set-up block.
interface pwmps_in_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      kind;
  logic [pwmps_pkg::FreqW-1:0]     frequency_hz;
  logic [pwmps_pkg::DutyW-1:0]     duty_value;
  logic [pwmps_pkg::PctW-1:0]      percent;
  logic [pwmps_pkg::ChanW-1:0]     channel;

  modport source (output valid, kind, frequency_hz, duty_value, percent, channel,
                  input ready);
  modport sink   (input valid, kind, frequency_hz, duty_value, percent, channel,
                  output ready);
endinterface

[sv/pwmps_out_if.sv]
// Result channel interface of the PWM set-up block.
interface pwmps_out_if;
  logic                        valid;
  logic                        ready;
  logic                        status;
  logic [pwmps_pkg::ByteW-1:0] period_register;
  logic [pwmps_pkg::ByteW-1:0] timer_control;
  logic [pwmps_pkg::ChanW-1:0] channel_written;
  logic [pwmps_pkg::ByteW-1:0] duty_high;
  logic [pwmps_pkg::ByteW-1:0] channel_control;
  logic                        duty_applied;

  modport source (output valid, status, period_register, timer_control, channel_written,
                         duty_high, channel_control, duty_applied,
                  input ready);
  modport sink   (input valid, status, period_register, timer_control, channel_written,
                        duty_high, channel_control, duty_applied,
                  output ready);
endinterface

[sv/pwm_period_prescaler_duty_setup.sv]
// Top level of the PWM period, prescaler and duty set-up block.
//
//   channel   direction  payload                                         handshake
//   in_if     sink       kind, frequency_hz, duty_value, percent,        valid/ready
//                        channel
//   out_if    source     status, period_register, timer_control,         valid/ready
//                        channel_written, duty_high, channel_control,
//                        duty_applied
//   cfg       write      cfg_wdata_i (peripheral clock in hertz)         cfg_we_i
//
// A frequency beat with a nonzero frequency, or a percent beat between 1 and 99, loads the
// serial divider at its accepting edge; the divider yields one quotient bit per cycle over the
// 27-bit dividend (as wide as the clock register), and the final step then forms the result.
// Every other beat goes from acceptance straight to the final step, which forms the result.
// The serial divider sets the rate; one beat is in work at a time, and the next beat is taken
// in the cycle after the result is formed, even while the previous result still waits in the
// output register.
// Reset clears the control state, sets the period count to 256, the timer control to zero
// and the clock register to 12 MHz. A stalled output holds the sequencer in its final step.
module pwm_period_prescaler_duty_setup #(
  parameter int unsigned CHANNELS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pwmps_pkg::ClkHzW-1:0]    cfg_wdata_i,
  pwmps_in_if.sink                        in_if,
  pwmps_out_if.source                     out_if
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN
  } state_e;

  state_e state_q, state_d;

  // Configuration and persistent timer settings.
  logic [pwmps_pkg::ClkHzW-1:0]   clk_hz_q, clk_hz_d;
  logic [pwmps_pkg::PeriodW-1:0]  ppo_q, ppo_d;
  logic [pwmps_pkg::ByteW-1:0]    tcon_q, tcon_d;

  // Fields of the beat in work.
  pwmps_pkg::kind_e               kind_q, kind_d;
  logic                           freq_zero_q, freq_zero_d;
  logic [pwmps_pkg::DutyW-1:0]    duty_q, duty_d;
  logic [pwmps_pkg::PctW-1:0]     pct_q, pct_d;
  logic [pwmps_pkg::ChanW-1:0]    chan_q, chan_d;

  // Output register.
  logic                           out_valid_q, out_valid_d;
  pwmps_pkg::result_t             res_q, res_d;

  // Divider connection.
  logic                           div_start;
  logic [pwmps_pkg::DivNumW-1:0]  div_num;
  logic [pwmps_pkg::DivDenW-1:0]  div_den;
  pwmps_pkg::div_stat_t           div_stat;
  logic [pwmps_pkg::DivNumW-1:0]  quotient;

  logic                           in_fire;
  logic                           out_free;
  logic                           pct_mid;
  logic [13:0]                    pct_prod;

  pwmps_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .stat_o     (div_stat),
    .quotient_o (quotient)
  );

  assign in_if.ready = (state_q == ST_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;
  assign out_free    = !out_valid_q || out_if.ready;

  // A percent strictly between zero and full scales a quarter of the period by the percent,
  // and the divider then takes out the constant 25.
  assign pct_mid  = (in_if.percent != '0) &&
                    (in_if.percent < pwmps_pkg::PctW'(pwmps_pkg::PctFull));
  assign pct_prod = 14'(in_if.percent[6:0]) * 14'(ppo_q[8:2]);

  always_comb begin
    div_start = 1'b0;
    div_num   = clk_hz_q;
    div_den   = in_if.frequency_hz;
    if (in_fire) begin
      if (pwmps_pkg::kind_e'(in_if.kind) == pwmps_pkg::KIND_FREQ) begin
        div_start = (in_if.frequency_hz != '0);
      end else if (pwmps_pkg::kind_e'(in_if.kind) == pwmps_pkg::KIND_PERCENT) begin
        div_start = pct_mid;
        div_num   = pwmps_pkg::DivNumW'(pct_prod);
        div_den   = pwmps_pkg::DivDenW'(pwmps_pkg::PctDivisor);
      end
    end
  end

  // Result formation, done in the final step once the output register is free.
  logic                           ratio_bad;
  logic [pwmps_pkg::Duty10W-1:0]  duty10;
  logic [pwmps_pkg::ByteW-1:0]    pct_duty;
  logic                           chan_ok;
  logic [pwmps_pkg::PeriodW-1:0]  ppo_minus_one;

  assign ratio_bad = freq_zero_q || (quotient == '0) ||
                     (quotient > pwmps_pkg::DivNumW'(pwmps_pkg::RatioMax));
  assign chan_ok   = (32'(chan_q) < CHANNELS);
  assign ppo_minus_one = ppo_q - 1'b1;

  always_comb begin
    if (pct_q == '0) begin
      pct_duty = '0;
    end else if (pct_q >= pwmps_pkg::PctW'(pwmps_pkg::PctFull)) begin
      pct_duty = ppo_minus_one[pwmps_pkg::ByteW-1:0];
    end else begin
      pct_duty = quotient[pwmps_pkg::ByteW-1:0];
    end
  end

  always_comb begin
    if (kind_q == pwmps_pkg::KIND_PERCENT) begin
      duty10 = {pct_duty, 2'b00};
    end else if (duty_q > pwmps_pkg::DutyW'(pwmps_pkg::DutyMax)) begin
      duty10 = pwmps_pkg::Duty10W'(pwmps_pkg::DutyMax);
    end else begin
      duty10 = duty_q[pwmps_pkg::Duty10W-1:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    clk_hz_d    = clk_hz_q;
    ppo_d       = ppo_q;
    tcon_d      = tcon_q;
    kind_d      = kind_q;
    freq_zero_d = freq_zero_q;
    duty_d      = duty_q;
    pct_d       = pct_q;
    chan_d      = chan_q;
    out_valid_d = out_valid_q && !out_if.ready;
    res_d       = res_q;

    if (cfg_we_i) begin
      clk_hz_d = cfg_wdata_i;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          kind_d      = pwmps_pkg::kind_e'(in_if.kind);
          freq_zero_d = (in_if.frequency_hz == '0);
          duty_d      = in_if.duty_value;
          pct_d       = in_if.percent;
          chan_d      = in_if.channel;
          state_d     = div_start ? ST_DIV : ST_FIN;
        end
      end
      ST_DIV: begin
        if (div_stat.last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          res_d = '0;
          unique case (kind_q) inside
            pwmps_pkg::KIND_FREQ: begin
              if (ratio_bad) begin
                res_d.status = 1'b1;
              end else if (quotient <= pwmps_pkg::DivNumW'(pwmps_pkg::RatioPrescale1)) begin
                ppo_d  = quotient[pwmps_pkg::PeriodW-1:0];
                tcon_d = pwmps_pkg::TconPrescale1;
              end else if (quotient <= pwmps_pkg::DivNumW'(pwmps_pkg::RatioPrescale4)) begin
                ppo_d  = quotient[pwmps_pkg::PeriodW+1:2];
                tcon_d = pwmps_pkg::TconPrescale4;
              end else begin
                ppo_d  = quotient[pwmps_pkg::PeriodW+3:4];
                tcon_d = pwmps_pkg::TconPrescale16;
              end
            end
            pwmps_pkg::KIND_DUTY, pwmps_pkg::KIND_PERCENT: begin
              res_d.channel_written = chan_q;
              if (chan_ok) begin
                res_d.duty_high       = duty10[pwmps_pkg::Duty10W-1:2];
                res_d.channel_control = pwmps_pkg::PwmMode | {2'b00, duty10[1:0], 4'b0000};
                res_d.duty_applied    = 1'b1;
              end
            end
            pwmps_pkg::KIND_NONE: begin
              res_d.status = 1'b0;
            end
            default: begin
              res_d = '0;
            end
          endcase
          res_d.period_register = 8'(ppo_d - 1'b1);
          res_d.timer_control   = tcon_d;
          out_valid_d           = 1'b1;
          state_d               = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      clk_hz_q    <= pwmps_pkg::ClkHzW'(pwmps_pkg::ClkHzReset);
      ppo_q       <= pwmps_pkg::PeriodW'(pwmps_pkg::PeriodReset);
      tcon_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clk_hz_q    <= clk_hz_d;
      ppo_q       <= ppo_d;
      tcon_q      <= tcon_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q      <= kind_d;
    freq_zero_q <= freq_zero_d;
    duty_q      <= duty_d;
    pct_q       <= pct_d;
    chan_q      <= chan_d;
    res_q       <= res_d;
  end

  assign out_if.valid           = out_valid_q;
  assign out_if.status          = res_q.status;
  assign out_if.period_register = res_q.period_register;
  assign out_if.timer_control   = res_q.timer_control;
  assign out_if.channel_written = res_q.channel_written;
  assign out_if.duty_high       = res_q.duty_high;
  assign out_if.channel_control = res_q.channel_control;
  assign out_if.duty_applied    = res_q.duty_applied;

  // The sequencer never takes a beat while the divider is still working.
  a_no_accept_while_dividing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> !in_if.ready)
    else $error("beat accepted while divider busy");

  // The period count always stays within one to 256.
  a_period_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ppo_q != '0) && (ppo_q <= pwmps_pkg::PeriodW'(pwmps_pkg::PeriodReset)))
    else $error("period count out of range");

  // A new result appears only out of the final step.
  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_if.valid) |-> $past(state_q == ST_FIN))
    else $error("result appeared outside final step");

  // The timer control shadow holds only zero or one of the three prescaler codes.
  a_tcon_codes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tcon_q == '0) || (tcon_q == pwmps_pkg::TconPrescale1) ||
    (tcon_q == pwmps_pkg::TconPrescale4) || (tcon_q == pwmps_pkg::TconPrescale16))
    else $error("timer control shadow corrupt");

endmodule

[sv/pwmps_div.sv]
// Restoring divider that produces one quotient bit per cycle.
module pwmps_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [pwmps_pkg::DivNumW-1:0]    dividend_i,
  input  logic [pwmps_pkg::DivDenW-1:0]    divisor_i,
  output pwmps_pkg::div_stat_t             stat_o,
  output logic [pwmps_pkg::DivNumW-1:0]    quotient_o
);

  logic                            busy_q, busy_d;
  logic [pwmps_pkg::DivCntW-1:0]   cnt_q, cnt_d;
  logic [pwmps_pkg::DivDenW-1:0]   rem_q, rem_d;
  logic [pwmps_pkg::DivDenW-1:0]   den_q, den_d;
  logic [pwmps_pkg::DivNumW-1:0]   quo_q, quo_d;
  logic [pwmps_pkg::DivDenW:0]     trial;
  logic [pwmps_pkg::DivDenW:0]     diff;

  // The dividend shifts out of the top of quo_q while quotient bits enter at the bottom.
  assign trial = {rem_q, quo_q[pwmps_pkg::DivNumW-1]};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = pwmps_pkg::DivCntW'(pwmps_pkg::DivNumW - 1);
      rem_d  = '0;
      den_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      if (!diff[pwmps_pkg::DivDenW]) begin
        rem_d = diff[pwmps_pkg::DivDenW-1:0];
      end else begin
        rem_d = trial[pwmps_pkg::DivDenW-1:0];
      end
      quo_d = {quo_q[pwmps_pkg::DivNumW-2:0], ~diff[pwmps_pkg::DivDenW]};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.last = busy_q && (cnt_q == '0);
  assign quotient_o  = quo_q;

endmodule
